### rtl/core/sinosc_pkg.sv
// sinosc_pkg: shared widths, types, register indexes and the sine table builder
package sinosc_pkg;

   localparam int TABLE_BITS    = 9;
   localparam int TABLE_ENTRIES = 1 << TABLE_BITS;
   localparam int FRACTION_BITS = 16;
   localparam int SAMPLE_BITS   = 16;
   localparam int PHASE_BITS    = TABLE_BITS + FRACTION_BITS;
   localparam int STEP_BITS     = 24;
   localparam int CSR_DATA_BITS = 25;
   localparam int DELTA_BITS    = SAMPLE_BITS + 1;
   localparam int PROD_BITS     = DELTA_BITS + FRACTION_BITS + 1;
   localparam int SUM_BITS      = PROD_BITS - FRACTION_BITS;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [63:0] AMP     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam int          HALF    = TABLE_ENTRIES / 2;
   localparam int          QUARTER = TABLE_ENTRIES / 4;

   typedef enum logic [0:0] {
      REG_PHASE_STEP  = 1'b0,
      REG_START_PHASE = 1'b1
   } reg_index_type;

   typedef logic [TABLE_ENTRIES-1:0][SAMPLE_BITS-1:0] rom_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] base;
      logic signed [DELTA_BITS-1:0]  delta;
      logic [FRACTION_BITS-1:0]      frac;
   } interp_type;

   // sin over [0, pi/2], argument and result in Q30
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] prod;
      longint      sum;
      int          n;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 10; n++) begin
         prod = (term * x2) >> 30;
         unique case (n)
            1: term = prod / 6;
            2: term = prod / 20;
            3: term = prod / 42;
            4: term = prod / 72;
            5: term = prod / 110;
            6: term = prod / 156;
            7: term = prod / 210;
            8: term = prod / 272;
            9: term = prod / 342;
            default: term = prod / 420;
         endcase
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
         sum = longint'(ONE_Q30);
      end
      return 64'(sum);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] h;
      logic [63:0] m;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] v;
      int          k;
      for (k = 0; k < TABLE_ENTRIES; k++) begin
         h = (k < HALF) ? 64'(k) : 64'(k - HALF);
         m = (h <= 64'(QUARTER)) ? h : 64'(HALF) - h;
         x = (m * 64'd2 * PI_Q30 + 64'(TABLE_ENTRIES / 2)) / TABLE_ENTRIES;
         s = sin_q30(x);
         v = (s * AMP + (ONE_Q30 >> 1)) >> 30;
         rom[k] = (k < HALF) ? v[SAMPLE_BITS-1:0] : SAMPLE_BITS'(-v);
      end
      return rom;
   endfunction

endpackage

### rtl/core/sinosc_phase.sv
// sinosc_phase: phase accumulator with restart load, first pipeline stage
module sinosc_phase (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 item_valid,
   input  logic                                 restart,
   input  logic [sinosc_pkg::STEP_BITS-1:0]     phase_step,
   input  logic [sinosc_pkg::PHASE_BITS-1:0]    start_phase,
   output logic [sinosc_pkg::PHASE_BITS-1:0]    phase,
   output logic                                 phase_valid
);

   logic [sinosc_pkg::PHASE_BITS-1:0] phase_ff;
   logic [sinosc_pkg::PHASE_BITS-1:0] phase_in;
   logic [sinosc_pkg::PHASE_BITS-1:0] origin;
   logic                              valid_ff;

   assign origin   = restart ? start_phase : phase_ff;
   assign phase_in = origin + sinosc_pkg::PHASE_BITS'(phase_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= item_valid;
         if (item_valid) begin
            phase_ff <= phase_in;
         end
      end
   end

   assign phase       = phase_ff;
   assign phase_valid = valid_ff;

endmodule

### rtl/core/sinosc_lookup.sv
// sinosc_lookup: reads neighboring sine table entries, second pipeline stage
module sinosc_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              phase_valid,
   input  logic [sinosc_pkg::PHASE_BITS-1:0] phase,
   output sinosc_pkg::interp_type            item,
   output logic                              item_valid
);

   localparam sinosc_pkg::rom_type SINE_ROM = sinosc_pkg::build_rom();

   logic [sinosc_pkg::TABLE_BITS-1:0]         index0;
   logic [sinosc_pkg::TABLE_BITS-1:0]         index1;
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0] entry0;
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0] entry1;
   sinosc_pkg::interp_type                    item_in;
   sinosc_pkg::interp_type                    item_ff;
   logic                                      valid_ff;

   assign index0 = phase[sinosc_pkg::PHASE_BITS-1:sinosc_pkg::FRACTION_BITS];
   assign index1 = index0 + sinosc_pkg::TABLE_BITS'(1);
   assign entry0 = $signed(SINE_ROM[index0]);
   assign entry1 = $signed(SINE_ROM[index1]);

   always_comb begin
      item_in.base  = entry0;
      item_in.delta = sinosc_pkg::DELTA_BITS'(entry1) - sinosc_pkg::DELTA_BITS'(entry0);
      item_in.frac  = phase[sinosc_pkg::FRACTION_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= phase_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

### rtl/core/sinosc_interp.sv
// sinosc_interp: linear interpolation with rounding into the result register
module sinosc_interp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     enable,
   input  logic                                     item_valid,
   input  sinosc_pkg::interp_type                   item,
   output logic signed [sinosc_pkg::SAMPLE_BITS-1:0] sample,
   output logic                                     sample_valid
);

   logic signed [sinosc_pkg::PROD_BITS-1:0]   product;
   logic signed [sinosc_pkg::PROD_BITS-1:0]   rounded;
   logic signed [sinosc_pkg::SUM_BITS-1:0]    offset;
   logic signed [sinosc_pkg::SUM_BITS-1:0]    total;
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0] sample_in;
   logic                                      valid_ff;

   assign product = sinosc_pkg::PROD_BITS'(item.delta)
                  * $signed(sinosc_pkg::PROD_BITS'({1'b0, item.frac}));
   assign rounded = product
                  + sinosc_pkg::PROD_BITS'(1 << (sinosc_pkg::FRACTION_BITS - 1));
   // arithmetic shift gives the floor
   assign offset    = rounded[sinosc_pkg::PROD_BITS-1:sinosc_pkg::FRACTION_BITS];
   assign total     = sinosc_pkg::SUM_BITS'(item.base) + offset;
   assign sample_in = total[sinosc_pkg::SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sample_ff <= sample_in;
      end
   end

   assign sample       = sample_ff;
   assign sample_valid = valid_ff;

endmodule

### rtl/core/sine_wavetable_oscillator_top.sv
// sine_wavetable_oscillator_top: sine oscillator with phase accumulator and table interpolation
//
// Each item on the req_ channel is one tick: req_restart high first loads
// start_phase, then phase_step is added to the 9.16 phase accumulator.
// The phase picks two neighboring entries of a 512-entry sine table, blended
// by the phase fraction and rounded to a signed Q1.15 item on rsp_sample.
// Registers are written over the csr_ channel (index 0 phase_step, index 1
// start_phase), taken in any cycle; the user must write them only while no
// item is in flight, which the block itself does not enforce. rsp_valid rises
// through three register stages: accumulator, table read, interpolation multiply.
// Throughput is one item per cycle while rsp_ready does not hold the pipeline.
// When rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the accumulator, both registers and all valid flags; the
// sine table is a constant and needs no fill.
module sine_wavetable_oscillator_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_restart,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [sinosc_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  sinosc_pkg::reg_index_type                 csr_index,
   input  logic [sinosc_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   logic [sinosc_pkg::STEP_BITS-1:0]  phase_step_ff;
   logic [sinosc_pkg::PHASE_BITS-1:0] start_phase_ff;
   logic [sinosc_pkg::PHASE_BITS-1:0] phase;
   logic                              phase_valid;
   sinosc_pkg::interp_type            interp_item;
   logic                              interp_valid;
   logic                              enable;

   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         start_phase_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sinosc_pkg::REG_PHASE_STEP: begin
               phase_step_ff <= csr_data[sinosc_pkg::STEP_BITS-1:0];
            end
            sinosc_pkg::REG_START_PHASE: begin
               start_phase_ff <= csr_data[sinosc_pkg::PHASE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   sinosc_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .item_valid  (req_valid),
      .restart     (req_restart),
      .phase_step  (phase_step_ff),
      .start_phase (start_phase_ff),
      .phase       (phase),
      .phase_valid (phase_valid)
   );

   sinosc_lookup u_lookup (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .phase_valid (phase_valid),
      .phase       (phase),
      .item        (interp_item),
      .item_valid  (interp_valid)
   );

   sinosc_interp u_interp (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .item_valid   (interp_valid),
      .item         (interp_item),
      .sample       (rsp_sample),
      .sample_valid (rsp_valid)
   );

endmodule

### test/sine_wavetable_oscillator_top_tb.sv
// testbench for the sine wavetable oscillator: directed and random ticks against a predictor
module sine_wavetable_oscillator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   localparam u64_type PI_FIXED       = 64'd3373259426;
   localparam u64_type ONE_FIXED      = 64'd1073741824;
   localparam int      STALL_LIMIT    = 4000;
   localparam int      PRINT_LIMIT    = 100;
   localparam int      SEGMENTS       = 6;
   localparam int      PRESSURE_ITEMS = 40;
   localparam int      HOLD_CYCLES    = 300;

   logic                                       clock = 1'b0;
   logic                                       reset;
   logic                                       req_valid;
   logic                                       req_ready;
   logic                                       req_restart;
   logic                                       rsp_valid;
   logic                                       rsp_ready = 1'b0;
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0]  rsp_sample;
   logic                                       csr_valid;
   logic                                       csr_ready;
   sinosc_pkg::reg_index_type                  csr_index;
   logic [sinosc_pkg::CSR_DATA_BITS-1:0]       csr_data;

   logic signed [sinosc_pkg::SAMPLE_BITS-1:0]  sine_table [sinosc_pkg::TABLE_ENTRIES];
   logic [sinosc_pkg::PHASE_BITS-1:0]          phase_accum;
   logic [sinosc_pkg::STEP_BITS-1:0]           step_setting;
   logic [sinosc_pkg::PHASE_BITS-1:0]          start_setting;
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0]  expected_samples [$];
   logic signed [sinosc_pkg::SAMPLE_BITS-1:0]  oldest_sample;
   int                                         mismatch_count = 0;
   int                                         sender_idle_pct = 0;
   int                                         receiver_idle_pct = 0;
   int                                         hold_remaining = 0;
   int                                         stalled_cycles = 0;

   sine_wavetable_oscillator_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #4 clock = ~clock;

   // sine over the first quarter wave, argument and result in Q30
   function automatic u64_type quarter_sine(input u64_type angle);
      u64_type angle_sq;
      u64_type term;
      longint  acc;
      int      n;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      acc      = longint'(angle);
      for (n = 1; n <= 10; n++) begin
         term = ((term * angle_sq) >> 30) / u64_type'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(ONE_FIXED)) begin
         acc = longint'(ONE_FIXED);
      end
      return u64_type'(acc);
   endfunction

   function automatic void fill_sine_table();
      u64_type amplitude;
      u64_type folded;
      u64_type mirrored;
      u64_type angle;
      u64_type magnitude;
      int      half;
      int      k;
      half      = sinosc_pkg::TABLE_ENTRIES / 2;
      amplitude = (u64_type'(1) << (sinosc_pkg::SAMPLE_BITS - 1)) - 1;
      for (k = 0; k < sinosc_pkg::TABLE_ENTRIES; k++) begin
         folded    = (k < half) ? u64_type'(k) : u64_type'(k - half);
         mirrored  = (folded <= sinosc_pkg::TABLE_ENTRIES / 4) ? folded : half - folded;
         angle     = (mirrored * 2 * PI_FIXED + half) / sinosc_pkg::TABLE_ENTRIES;
         magnitude = (quarter_sine(angle) * amplitude + (ONE_FIXED >> 1)) >> 30;
         sine_table[k] = (k < half) ? sinosc_pkg::SAMPLE_BITS'(magnitude)
                                    : sinosc_pkg::SAMPLE_BITS'(-longint'(magnitude));
      end
   endfunction

   function automatic logic signed [sinosc_pkg::SAMPLE_BITS-1:0] advance_oscillator(
      input logic restart);
      logic [sinosc_pkg::TABLE_BITS-1:0]    lo_index;
      logic [sinosc_pkg::TABLE_BITS-1:0]    hi_index;
      logic [sinosc_pkg::FRACTION_BITS-1:0] frac;
      longint                               lo;
      longint                               hi;
      longint                               blend;
      if (restart) begin
         phase_accum = start_setting;
      end
      phase_accum = phase_accum + {1'b0, step_setting};
      lo_index    = phase_accum[sinosc_pkg::PHASE_BITS-1:sinosc_pkg::FRACTION_BITS];
      hi_index    = lo_index + sinosc_pkg::TABLE_BITS'(1);
      frac        = phase_accum[sinosc_pkg::FRACTION_BITS-1:0];
      lo          = sine_table[lo_index];
      hi          = sine_table[hi_index];
      blend       = (hi - lo) * longint'(frac)
                  + (longint'(1) << (sinosc_pkg::FRACTION_BITS - 1));
      return sinosc_pkg::SAMPLE_BITS'(lo + (blend >>> sinosc_pkg::FRACTION_BITS));
   endfunction

   function automatic logic [sinosc_pkg::CSR_DATA_BITS-1:0] choose_word();
      unique case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return sinosc_pkg::CSR_DATA_BITS'($urandom_range(4095));
         default: return sinosc_pkg::CSR_DATA_BITS'($urandom());
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int expected, input int got);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, expected, got);
      end
      mismatch_count++;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_idle_pct <= receiver_pct;
   endtask

   task automatic send_tick(input logic restart);
      bit idled;
      idled = 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
         if (!idled) begin
            req_valid <= 1'b0;
         end
         idled = 1'b1;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(advance_oscillator(restart));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic load_oscillator(input logic [sinosc_pkg::CSR_DATA_BITS-1:0] step_word,
                                  input logic [sinosc_pkg::CSR_DATA_BITS-1:0] start_word);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= sinosc_pkg::REG_PHASE_STEP;
      csr_data  <= step_word;
      do @(posedge clock); while (!csr_ready);
      step_setting = step_word[sinosc_pkg::STEP_BITS-1:0];
      csr_index <= sinosc_pkg::REG_START_PHASE;
      csr_data  <= start_word;
      do @(posedge clock); while (!csr_ready);
      start_setting = start_word;
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      set_idling(10, 10);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   task automatic test_table_edges();
      // last entry blends into entry zero, fraction all ones
      load_oscillator('0, '1);
      send_tick(1'b1);
      send_tick(1'b0);
      // exact half fraction, rounding ties upward
      load_oscillator('0, {9'd511, 16'h8000});
      send_tick(1'b1);
      load_oscillator('0, {9'd100, 16'h8000});
      send_tick(1'b1);
      load_oscillator('0, {9'd300, 16'h8000});
      send_tick(1'b1);
      // positive and negative peaks
      load_oscillator('0, {9'd128, 16'h0000});
      send_tick(1'b1);
      load_oscillator('0, {9'd384, 16'h0000});
      send_tick(1'b1);
   endtask

   task automatic test_step_extremes();
      // top data bit lies beyond the step register
      load_oscillator('1, '1);
      repeat (4) send_tick(1'b0);
      send_tick(1'b1);
      load_oscillator(25'd1, '0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      // whole-entry step, accumulator wraps past the top
      load_oscillator(25'h0010000, 25'h1FF0000);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
   endtask

   task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                    input int items);
      int seg;
      int i;
      set_idling(sender_pct, receiver_pct);
      for (seg = 0; seg < SEGMENTS; seg++) begin
         load_oscillator(choose_word(), choose_word());
         for (i = 0; i < items / SEGMENTS; i++) begin
            send_tick($urandom_range(7) == 0);
         end
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      int i;
      set_idling(0, 0);
      load_oscillator(choose_word(), choose_word());
      hold_remaining <= HOLD_CYCLES;
      for (i = 0; i < PRESSURE_ITEMS; i++) begin
         send_tick($urandom_range(7) == 0);
      end
      drain_results();
      for (i = 0; i < PRESSURE_ITEMS / 4; i++) begin
         send_tick(1'b0);
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      if (hold_remaining != 0) begin
         hold_remaining <= hold_remaining - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("item with none expected", 0, rsp_sample);
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_sample !== oldest_sample) begin
               report_mismatch("rsp_sample", oldest_sample, rsp_sample);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_restart   = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = sinosc_pkg::REG_PHASE_STEP;
      csr_data      = '0;
      phase_accum   = '0;
      step_setting  = '0;
      start_setting = '0;
      fill_sine_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_table_edges();
      test_step_extremes();
      test_random_phase(20, 71, 300);
      test_random_phase(71, 20, 300);
      test_random_phase(0, 0, 300);
      test_backpressure();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
